// ===== sv/blpe_pkg.sv =====
// Shared types and constants for the black level percentile estimator.
package blpe_pkg;

   // Configuration register indexes
   localparam logic CSR_DARK_RATIO  = 1'b0;
   localparam logic CSR_LEVEL_LIMIT = 1'b1;

   // Field widths fixed by the interface
   localparam int PIX_W   = 8;
   localparam int RATIO_W = 16;
   localparam int LEVEL_W = 8;
   localparam int CSR_W   = 16;

   // Register reset values
   localparam logic [RATIO_W-1:0] DARK_RATIO_RESET  = 16'd655;
   localparam logic [LEVEL_W-1:0] LEVEL_LIMIT_RESET = 8'd64;

   // Commands from the controller to the datapath
   typedef struct packed {
      logic accept;   // pixel transfer this cycle
      logic sweep;    // write zero at the bin counter and step it
      logic scan;     // the sweep also reads bins for the percentile scan
      logic capture;  // latch target, start scan sums, clear pixel count
      logic report;   // load the clamped levels into the result registers
   } ctl_cmd_type;

   // Status from the datapath to the controller
   typedef struct packed {
      logic cnt_last; // bin counter is at the last bin
   } ctl_status_type;

endpackage

// ===== sv/blpe_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module blpe_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Read returns the old contents on a same-address write
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== sv/blpe_chan.sv =====
// One color channel: histogram memory, bin update pipeline and percentile scan.
module blpe_chan
   import blpe_pkg::*;
#(
   parameter int BIN_COUNT  = 256,
   parameter int COUNT_BITS = 24
) (
   input  logic                         clock,
   input  logic                         reset,
   input  ctl_cmd_type                  cmd,
   input  logic [PIX_W-1:0]             pix,
   input  logic [$clog2(BIN_COUNT)-1:0] cnt,
   input  logic [COUNT_BITS-1:0]        target_hi,
   input  logic [LEVEL_W-1:0]           limit,
   output logic [LEVEL_W-1:0]           level
);

   localparam int IDX_W = $clog2(BIN_COUNT);
   localparam int SUM_W = COUNT_BITS + IDX_W;
   localparam int LVL_W = $clog2(BIN_COUNT + 1);

   // Update pipeline stage and last write for forwarding
   logic                  s1_valid_ff;
   logic [PIX_W-1:0]      s1_addr_ff;
   logic                  wl_valid_ff;
   logic [PIX_W-1:0]      wl_addr_ff;
   logic [COUNT_BITS-1:0] wl_data_ff;

   // Scan state
   logic                  rd_valid_ff;
   logic [IDX_W-1:0]      rd_idx_ff;
   logic [SUM_W-1:0]      sum_ff, sum_in;
   logic                  found_ff;
   logic [LVL_W-1:0]      level_ff;
   logic [LEVEL_W-1:0]    level_out_ff;

   logic                  ram_we;
   logic [IDX_W-1:0]      ram_waddr;
   logic [COUNT_BITS-1:0] ram_wdata;
   logic [IDX_W-1:0]      ram_raddr;
   logic [COUNT_BITS-1:0] ram_rdata;
   logic [COUNT_BITS-1:0] bin_base;
   logic [COUNT_BITS-1:0] bin_inc;
   logic                  hit;

   // Forward the previous write when it went to the same bin
   always_comb begin
      bin_base = (wl_valid_ff && (wl_addr_ff == s1_addr_ff)) ? wl_data_ff : ram_rdata;
      bin_inc  = bin_base + COUNT_BITS'(1);
   end

   // Memory port selection: sweep owns the ports, else pixel update
   always_comb begin
      ram_raddr = cmd.sweep ? cnt : IDX_W'(pix);
      ram_we    = cmd.sweep | s1_valid_ff;
      ram_waddr = cmd.sweep ? cnt : IDX_W'(s1_addr_ff);
      ram_wdata = cmd.sweep ? '0 : bin_inc;
   end

   blpe_ram #(
      .WIDTH(COUNT_BITS),
      .DEPTH(BIN_COUNT)
   ) u_bins (
      .clock  (clock),
      .wr_en  (ram_we),
      .wr_addr(ram_waddr),
      .wr_data(ram_wdata),
      .rd_addr(ram_raddr),
      .rd_data(ram_rdata)
   );

   // Running sum and first crossing of the target
   always_comb begin
      sum_in = sum_ff + SUM_W'(ram_rdata);
      hit    = rd_valid_ff && !found_ff && (sum_in > SUM_W'(target_hi));
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         wl_valid_ff <= 1'b0;
         rd_valid_ff <= 1'b0;
         found_ff    <= 1'b0;
      end else begin
         s1_valid_ff <= cmd.accept;
         wl_valid_ff <= s1_valid_ff;
         rd_valid_ff <= cmd.sweep & cmd.scan;
         if (cmd.capture) begin
            found_ff <= 1'b0;
         end else if (hit) begin
            found_ff <= 1'b1;
         end
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      s1_addr_ff <= pix;
      wl_addr_ff <= s1_addr_ff;
      wl_data_ff <= bin_inc;
      rd_idx_ff  <= cnt;
      if (cmd.capture) begin
         sum_ff   <= '0;
         level_ff <= LVL_W'(BIN_COUNT);
      end else if (rd_valid_ff) begin
         sum_ff <= sum_in;
         if (hit) begin
            level_ff <= LVL_W'(rd_idx_ff) + LVL_W'(1);
         end
      end
      // Clamp to the limit register
      if (cmd.report) begin
         level_out_ff <= (level_ff > LVL_W'(limit)) ? limit : level_ff[LEVEL_W-1:0];
      end
   end

   assign level = level_out_ff;

endmodule

// ===== sv/blpe_datapath.sv =====
// Datapath: configuration registers, pixel counter, target and three channels.
module blpe_datapath
   import blpe_pkg::*;
#(
   parameter int BIN_COUNT  = 256,
   parameter int COUNT_BITS = 24
) (
   input  logic                 clock,
   input  logic                 reset,
   input  ctl_cmd_type          cmd,
   output ctl_status_type       status,
   input  logic [PIX_W-1:0]     req_red_value,
   input  logic [PIX_W-1:0]     req_green_value,
   input  logic [PIX_W-1:0]     req_blue_value,
   input  logic                 csr_we,
   input  logic                 csr_index,
   input  logic [CSR_W-1:0]     csr_wdata,
   output logic [LEVEL_W-1:0]   rsp_red_level,
   output logic [LEVEL_W-1:0]   rsp_green_level,
   output logic [LEVEL_W-1:0]   rsp_blue_level
);

   localparam int IDX_W  = $clog2(BIN_COUNT);
   localparam int PROD_W = COUNT_BITS + RATIO_W;

   logic [RATIO_W-1:0]    ratio_ff;
   logic [LEVEL_W-1:0]    limit_ff;
   logic [COUNT_BITS-1:0] pixel_count_ff;
   logic [COUNT_BITS-1:0] target_hi_ff;
   logic [IDX_W-1:0]      cnt_ff;
   logic                  cnt_last;
   logic [PROD_W-1:0]     target_prod;

   assign cnt_last        = (cnt_ff == IDX_W'(BIN_COUNT - 1));
   assign status.cnt_last = cnt_last;

   // sum * 2^16 > count * ratio  is the same as  sum > (count * ratio) >> 16
   assign target_prod = PROD_W'(pixel_count_ff) * PROD_W'(ratio_ff);

   // Configuration, pixel counter and bin counter
   always_ff @(posedge clock) begin
      if (reset) begin
         ratio_ff       <= DARK_RATIO_RESET;
         limit_ff       <= LEVEL_LIMIT_RESET;
         pixel_count_ff <= '0;
         cnt_ff         <= '0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_DARK_RATIO:  ratio_ff <= csr_wdata[RATIO_W-1:0];
               CSR_LEVEL_LIMIT: limit_ff <= csr_wdata[LEVEL_W-1:0];
               default: ;
            endcase
         end
         if (cmd.capture) begin
            pixel_count_ff <= '0;
         end else if (cmd.accept) begin
            pixel_count_ff <= pixel_count_ff + COUNT_BITS'(1);
         end
         if (cmd.sweep) begin
            cnt_ff <= cnt_last ? '0 : cnt_ff + IDX_W'(1);
         end
      end
   end

   // Dark target, upper part of the product
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         target_hi_ff <= target_prod[PROD_W-1:RATIO_W];
      end
   end

   blpe_chan #(.BIN_COUNT(BIN_COUNT), .COUNT_BITS(COUNT_BITS)) u_red (
      .clock(clock), .reset(reset), .cmd(cmd), .pix(req_red_value), .cnt(cnt_ff),
      .target_hi(target_hi_ff), .limit(limit_ff), .level(rsp_red_level)
   );

   blpe_chan #(.BIN_COUNT(BIN_COUNT), .COUNT_BITS(COUNT_BITS)) u_green (
      .clock(clock), .reset(reset), .cmd(cmd), .pix(req_green_value), .cnt(cnt_ff),
      .target_hi(target_hi_ff), .limit(limit_ff), .level(rsp_green_level)
   );

   blpe_chan #(.BIN_COUNT(BIN_COUNT), .COUNT_BITS(COUNT_BITS)) u_blue (
      .clock(clock), .reset(reset), .cmd(cmd), .pix(req_blue_value), .cnt(cnt_ff),
      .target_hi(target_hi_ff), .limit(limit_ff), .level(rsp_blue_level)
   );

endmodule

// ===== sv/blpe_ctrl.sv =====
// Controller state machine: clearing pass, pixel intake, scan and report.
module blpe_ctrl
   import blpe_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           start,
   input  logic           last_pixel,
   input  ctl_status_type status,
   output logic           busy,
   output ctl_cmd_type    cmd,
   output logic           rsp_valid
);

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_DRAIN,
      ST_SCAN,
      ST_FLUSH,
      ST_REPORT
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff;

   // Next state and commands
   always_comb begin
      state_in    = state_ff;
      cmd         = '0;
      cmd.accept  = start && (state_ff == ST_IDLE);
      case (state_ff)
         ST_CLEAR: begin
            cmd.sweep = 1'b1;
            if (status.cnt_last) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (cmd.accept && last_pixel) state_in = ST_DRAIN;
         end
         ST_DRAIN: begin
            cmd.capture = 1'b1;
            state_in    = ST_SCAN;
         end
         ST_SCAN: begin
            cmd.sweep = 1'b1;
            cmd.scan  = 1'b1;
            if (status.cnt_last) state_in = ST_FLUSH;
         end
         ST_FLUSH: begin
            state_in = ST_REPORT;
         end
         ST_REPORT: begin
            cmd.report = 1'b1;
            state_in   = ST_IDLE;
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   // State and registered strobe
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= (state_ff == ST_REPORT);
      end
   end

   assign busy      = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

// ===== sv/black_level_percentile_estimator_top.sv =====
// Top level of the black level percentile estimator.
// Usage:
//   Pixels enter on req_red_value, req_green_value, req_blue_value and
//   req_last_pixel; a pixel is transferred at a clock edge with start high
//   and busy low. Pixels within a frame are taken one per cycle: the bin
//   update is a read-modify-write on each channel's histogram RAM
//   with forwarding for repeated bins.
//   After the pixel marked last is transferred, busy stays high while the
//   block forms the dark target, sweeps the histogram RAMs through their
//   single read port over all BIN_COUNT bins (each bin is zeroed behind
//   the read), flushes the read pipeline and clamps the levels. rsp_valid
//   is then high for one cycle with rsp_red_level, rsp_green_level and
//   rsp_blue_level; busy is already low in that cycle. The receiver cannot
//   stall results.
//   Frames without a last pixel produce no result.
//   Registers are written through csr_we, csr_index and csr_wdata. The
//   user must write them only while the block is idle; the block itself
//   does not enforce this. Reset (synchronous, active high) restores the
//   register defaults and clears all BIN_COUNT bins with busy high.
module black_level_percentile_estimator_top
   import blpe_pkg::*;
#(
   parameter int BIN_COUNT  = 256,
   parameter int COUNT_BITS = 24
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic [PIX_W-1:0]   req_red_value,
   input  logic [PIX_W-1:0]   req_green_value,
   input  logic [PIX_W-1:0]   req_blue_value,
   input  logic               req_last_pixel,
   output logic               rsp_valid,
   output logic [LEVEL_W-1:0] rsp_red_level,
   output logic [LEVEL_W-1:0] rsp_green_level,
   output logic [LEVEL_W-1:0] rsp_blue_level,
   input  logic               csr_we,
   input  logic               csr_index,
   input  logic [CSR_W-1:0]   csr_wdata
);

   ctl_cmd_type    cmd;
   ctl_status_type status;

   blpe_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .last_pixel(req_last_pixel),
      .status    (status),
      .busy      (busy),
      .cmd       (cmd),
      .rsp_valid (rsp_valid)
   );

   blpe_datapath #(
      .BIN_COUNT (BIN_COUNT),
      .COUNT_BITS(COUNT_BITS)
   ) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .status         (status),
      .req_red_value  (req_red_value),
      .req_green_value(req_green_value),
      .req_blue_value (req_blue_value),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .rsp_red_level  (rsp_red_level),
      .rsp_green_level(rsp_green_level),
      .rsp_blue_level (rsp_blue_level)
   );

endmodule

// ===== sv/blpe_checker.sv =====
// Port-level checks for the black level percentile estimator, bound to the top.
module blpe_checker (
   input logic clock,
   input logic reset,
   input logic start,
   input logic busy,
   input logic req_last_pixel,
   input logic rsp_valid
);

   // A result strobe lasts a single cycle
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe longer than one cycle");

   // The strobe comes while the block already takes pixels
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("result strobe while busy");

   // Transfer of a frame's last pixel makes the block busy for the scan
   assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_last_pixel) |=> busy)
      else $error("no scan after last pixel");

   // Pixels inside a frame stream without a stall
   assert property (@(posedge clock) disable iff (reset)
      (start && !busy && !req_last_pixel) |=> !busy)
      else $error("stall inside a frame");

endmodule

bind black_level_percentile_estimator_top blpe_checker u_blpe_checker (
   .clock         (clock),
   .reset         (reset),
   .start         (start),
   .busy          (busy),
   .req_last_pixel(req_last_pixel),
   .rsp_valid     (rsp_valid)
);
